// ----- rtl/core/css_pkg.sv -----
// Shared types and constants for the chained step sequencer.
package css_pkg;

    localparam int PATTERN_COUNT_DEF = 8;
    localparam int ROW_COUNT_DEF     = 4;
    localparam int STEP_COUNT_DEF    = 16;

    // Factory rows of pattern 0, row 0 first
    localparam logic [15:0] SEED_ROWS [4] = '{16'h2222, 16'h0000, 16'h8888, 16'h5555};

    localparam logic [7:0] FPS_RST     = 8'd8;
    localparam logic [3:0] VOICE_A_RST = 4'd7;
    localparam logic [3:0] VOICE_B_RST = 4'd8;
    localparam logic [3:0] VOICE_C_RST = 4'd0;
    localparam logic [3:0] VOICE_D_RST = 4'd3;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_TOGGLE = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_SELECT = 3'd3,
        FN_CHAIN  = 3'd4,
        FN_RUN    = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        REG_FPS     = 3'd0,
        REG_VOICE_A = 3'd1,
        REG_VOICE_B = 3'd2,
        REG_VOICE_C = 3'd3,
        REG_VOICE_D = 3'd4
    } t_reg;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- rtl/core/chained_step_sequencer.sv -----
// Chained drum step sequencer: pattern memory, chain control, frame divider and trigger output.
// Flow: an accepted item's pattern word is read into registers, then modified and written back
//   as the result is loaded into the output register; a stalled output holds the item in execute.
// The input is held not ready until that read-modify-write of the pattern memory is done.
// Reset: synchronous, active low; control state and registers take their initial values and
//   the per-pattern valid bits clear, so pattern 0 reads its seed rows and the rest read zero.
module chained_step_sequencer
    import css_pkg::*;
#(
    parameter int PATTERN_COUNT = PATTERN_COUNT_DEF,
    parameter int ROW_COUNT     = ROW_COUNT_DEF,
    parameter int STEP_COUNT    = STEP_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // pattern_sel[2:0], row_sel[4:3], step_sel[8:5],
                                       // chain_len_in[12:9], zero[15:13]
    input  logic [2:0]  s_axis_tuser,  // func[2:0]
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // trigger_mask[3:0], voice_a[7:4], voice_b[11:8],
                                       // voice_c[15:12], voice_d[19:16], current_step[23:20],
                                       // audible_pattern[26:24], editing_pattern[29:27],
                                       // is_running[30], zero[31]
    output logic        m_axis_tuser,  // fired[0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW     = $clog2(PATTERN_COUNT);
    localparam int SW     = $clog2(STEP_COUNT);
    localparam int CLW    = $clog2(PATTERN_COUNT + 1);
    localparam int WORD_W = ROW_COUNT * STEP_COUNT;
    localparam int MR     = (ROW_COUNT < 4) ? ROW_COUNT : 4;

    function automatic logic [WORD_W-1:0] f_seed();
        logic [WORD_W-1:0] w;
        w = '0;
        for (int r = 0; r < 4; r++) begin
            for (int s = 0; s < 16; s++) begin
                if (r < ROW_COUNT && s < STEP_COUNT) begin
                    w[r*STEP_COUNT+s] = SEED_ROWS[r][s];
                end
            end
        end
        return w;
    endfunction

    localparam logic [WORD_W-1:0] SEED_WORD = f_seed();

    // input fields
    logic [2:0] in_psel;
    logic [1:0] in_rsel;
    logic [3:0] in_ssel;
    logic [3:0] in_clen;
    t_func      in_func;

    assign in_psel = s_axis_tdata[2:0];
    assign in_rsel = s_axis_tdata[4:3];
    assign in_ssel = s_axis_tdata[8:5];
    assign in_clen = s_axis_tdata[12:9];
    assign in_func = t_func'(s_axis_tuser);

    // configuration registers
    logic [7:0] r_fps;
    logic [3:0] r_voice_a, r_voice_b, r_voice_c, r_voice_d;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps     <= FPS_RST;
            r_voice_a <= VOICE_A_RST;
            r_voice_b <= VOICE_B_RST;
            r_voice_c <= VOICE_C_RST;
            r_voice_d <= VOICE_D_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_FPS:     r_fps     <= pwdata[7:0];
                REG_VOICE_A: r_voice_a <= pwdata[3:0];
                REG_VOICE_B: r_voice_b <= pwdata[3:0];
                REG_VOICE_C: r_voice_c <= pwdata[3:0];
                REG_VOICE_D: r_voice_d <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_FPS:     prdata = {24'd0, r_fps};
            REG_VOICE_A: prdata = {28'd0, r_voice_a};
            REG_VOICE_B: prdata = {28'd0, r_voice_b};
            REG_VOICE_C: prdata = {28'd0, r_voice_c};
            REG_VOICE_D: prdata = {28'd0, r_voice_d};
            default:     prdata = '0;
        endcase
    end

    // sequencer state
    t_state                r_state, n_state;
    logic [7:0]            r_phase, n_phase;
    logic [SW-1:0]         r_step, n_step;
    logic [SW-1:0]         r_last, n_last;
    logic [PW-1:0]         r_cpos, n_cpos;
    logic [CLW-1:0]        r_clen, n_clen;
    logic [PW-1:0]         r_edit, n_edit;
    logic [PW-1:0]         r_play, n_play;
    logic                  r_run, n_run;
    logic [PATTERN_COUNT-1:0] r_valid;

    // item held between read and write-back
    t_func                 r_op;
    logic                  r_fired, n_fired;
    logic [PW-1:0]         r_addr, n_addr;
    logic                  r_rd_valid;
    logic [ROW_COUNT-1:0]  r_row_oh, n_row_oh;
    logic [STEP_COUNT-1:0] r_step_oh, n_step_oh;

    // output register
    logic                  r_out_valid;
    logic [31:0]           r_out_data;
    logic                  r_out_fired;

    logic                  in_xfer;
    logic                  out_free;
    logic                  exec_done;
    logic                  ram_we;
    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     word;
    logic [WORD_W-1:0]     wr_word;
    logic [3:0]            trig;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign exec_done     = (r_state == S_EXEC) && out_free;

    // next state and outputs of the item sequencing
    always_comb begin
        logic         fire;
        logic         adv;
        logic [8:0]   period;
        logic [8:0]   ph1;
        logic [CLW-1:0] cpos_inc;

        n_state   = r_state;
        n_phase   = r_phase;
        n_step    = r_step;
        n_last    = r_last;
        n_cpos    = r_cpos;
        n_clen    = r_clen;
        n_edit    = r_edit;
        n_play    = r_play;
        n_run     = r_run;
        n_fired   = 1'b0;
        n_addr    = r_edit;

        fire     = r_run && (r_phase == 8'd0);
        adv      = fire && (r_step == '0) && (r_last != '0) && (r_clen > CLW'(1));
        period   = (r_fps == 8'd0) ? 9'd1 : {1'b0, r_fps};
        ph1      = {1'b0, r_phase} + 9'd1;
        cpos_inc = CLW'(r_cpos) + CLW'(1);

        for (int r = 0; r < ROW_COUNT; r++) begin
            n_row_oh[r] = (int'(in_rsel) == r);
        end
        for (int s = 0; s < STEP_COUNT; s++) begin
            n_step_oh[s] = (int'(in_ssel) == s);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                    unique case (in_func)
                        FN_TICK: begin
                            if (fire) begin
                                if (adv) begin
                                    n_cpos = (cpos_inc == r_clen) ? '0 : r_cpos + PW'(1);
                                end
                                n_last  = r_step;
                                n_play  = (r_clen > CLW'(1)) ? n_cpos : r_edit;
                                n_fired = 1'b1;
                            end
                            n_addr = n_play;
                            if (ph1 >= period) begin
                                n_phase = 8'd0;
                                n_step  = (r_step == SW'(STEP_COUNT - 1)) ? '0 : r_step + SW'(1);
                            end else begin
                                n_phase = ph1[7:0];
                            end
                        end
                        FN_SELECT: begin
                            if (int'(in_psel) < PATTERN_COUNT) begin
                                n_edit = PW'(in_psel);
                            end
                        end
                        FN_CHAIN: begin
                            priority if (in_clen == 4'd0) begin
                                n_clen = CLW'(1);
                            end else if (int'(in_clen) > PATTERN_COUNT) begin
                                n_clen = CLW'(PATTERN_COUNT);
                            end else begin
                                n_clen = CLW'(in_clen);
                            end
                            n_cpos = '0;
                        end
                        FN_RUN: n_run = !r_run;
                        default: ;
                    endcase
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 8'd0;
            r_step      <= '0;
            r_last      <= '0;
            r_cpos      <= '0;
            r_clen      <= CLW'(1);
            r_edit      <= '0;
            r_play      <= '0;
            r_run       <= 1'b1;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_last  <= n_last;
            r_cpos  <= n_cpos;
            r_clen  <= n_clen;
            r_edit  <= n_edit;
            r_play  <= n_play;
            r_run   <= n_run;
            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op       <= in_func;
            r_fired    <= n_fired;
            r_addr     <= n_addr;
            r_rd_valid <= r_valid[n_addr];
            r_row_oh   <= n_row_oh;
            r_step_oh  <= n_step_oh;
        end
        if (exec_done) begin
            r_out_fired <= r_fired;
            r_out_data  <= {1'b0, r_run, 3'(r_edit), 3'(r_play), 4'(r_last),
                            r_voice_d, r_voice_c, r_voice_b, r_voice_a, trig};
        end
    end

    css_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PATTERN_COUNT)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_word),
        .i_re    (in_xfer),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

    // a pattern never written reads as its reset contents
    assign word = r_rd_valid ? ram_rdata : ((r_addr == '0) ? SEED_WORD : '0);

    always_comb begin
        logic [WORD_W-1:0]     tgl;
        logic [WORD_W-1:0]     clr;
        logic [STEP_COUNT-1:0] row_bits;
        for (int i = 0; i < WORD_W; i++) begin
            tgl[i] = r_row_oh[i / STEP_COUNT] & r_step_oh[i % STEP_COUNT];
            clr[i] = r_row_oh[i / STEP_COUNT];
        end
        wr_word = (r_op == FN_TOGGLE) ? (word ^ tgl) : (word & ~clr);
        trig    = 4'd0;
        for (int r = 0; r < MR; r++) begin
            row_bits = word[r*STEP_COUNT +: STEP_COUNT];
            trig[r]  = r_fired & row_bits[r_last];
        end
    end

    assign ram_we = exec_done && ((r_op == FN_TOGGLE) || (r_op == FN_CLEAR));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_fired;

    // checks
    a_chain_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CLW'(r_cpos) < r_clen)
        else $error("chain position reached chain length");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EXEC) && out_free)
        else $error("pattern write outside execute");

    a_fired_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[30])
        else $error("step fired while stopped");

    a_mask_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("trigger mask set without a played step");

endmodule

// ----- rtl/core/css_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module css_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
